[src/scm_pkg.sv]
`timescale 1ns / 1ps

package scm_pkg;

    localparam int TOKEN_SIZE  = 64;
    localparam int CNT_W       = $clog2(TOKEN_SIZE);
    localparam int CHAR_W      = 8;
    localparam int KIND_W      = 3;
    localparam int TLEN_W      = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
    localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

    typedef enum logic [KIND_W-1:0] {
        KIND_ERR  = 3'd0,
        KIND_END  = 3'd1,
        KIND_IN   = 3'd2,
        KIND_OUT  = 3'd3,
        KIND_RUN  = 3'd4,
        KIND_NAME = 3'd5,
        KIND_ARG  = 3'd6
    } kind_t;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] out_char;
        logic              token_done;
        kind_t             token_kind;
        logic [TLEN_W-1:0] token_length;
        logic              run_last;
    } result_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_name_char(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A) || c == CH_USCORE || c == CH_DOT ||
               c == CH_TILDE || c == CH_MINUS;
    endfunction

    function automatic logic is_print(input logic [CHAR_W-1:0] c);
        return (c >= CH_SPACE) && (c <= CH_TILDE);
    endfunction

endpackage

[src/scm_scan.sv]
`timescale 1ns / 1ps

module scm_scan (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [scm_pkg::CHAR_W-1:0]      chr,
    output scm_pkg::result_t [1:0]          res,
    output logic [1:0]                      res_cnt
);
    import scm_pkg::*;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_NAME  = 2'd1,
        PH_ARG   = 2'd2
    } phase_t;

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(TOKEN_SIZE - 1);

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  len_reg, len_next;

    result_t [1:0]     res_v;
    logic [1:0]        n_v;
    logic              consume_v;
    logic [CNT_W-1:0]  cnt_inc;
    logic              last_idx;

    function automatic result_t mk(input logic v, input logic [CHAR_W-1:0] c,
                                   input logic d, input kind_t k,
                                   input logic [CNT_W-1:0] l);
        result_t r;
        r.char_valid   = v;
        r.out_char     = v ? c : '0;
        r.token_done   = d;
        r.token_kind   = d ? k : KIND_ERR;
        r.token_length = d ? TLEN_W'(l) : '0;
        r.run_last     = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        res_v      = '0;
        n_v        = 2'd0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        consume_v  = 1'b0;
        cnt_inc    = '0;
        last_idx   = 1'b0;

        // a character that cannot continue a name closes it and is rescanned
        if (phase_reg == PH_NAME && !is_name_char(chr))
        begin
            res_v[0]   = mk(1'b0, CH_NUL, 1'b1, KIND_NAME, len_reg);
            n_v        = 2'd1;
            phase_next = PH_START;
            cnt_next   = '0;
            len_next   = '0;
        end

        case (phase_next)
            PH_NAME:
            begin
                len_next        = len_next + 1'b1;
                res_v[n_v[0]]   = mk(1'b1, chr, 1'b0, KIND_ERR, '0);
                n_v             = n_v + 2'd1;
                consume_v       = 1'b1;
            end
            PH_ARG:
            begin
                if (chr == CH_RPAR)
                begin
                    res_v[n_v[0]] = mk(1'b0, CH_NUL, 1'b1, KIND_ARG, len_next);
                    n_v           = n_v + 2'd1;
                    phase_next    = PH_START;
                    cnt_next      = '0;
                    len_next      = '0;
                end
                else if (chr == CH_LPAR || !is_print(chr))
                begin
                    res_v[n_v[0]] = mk(1'b0, CH_NUL, 1'b1, KIND_ERR, len_next);
                    n_v           = n_v + 2'd1;
                    phase_next    = PH_START;
                    cnt_next      = '0;
                    len_next      = '0;
                end
                else
                begin
                    len_next      = len_next + 1'b1;
                    res_v[n_v[0]] = mk(1'b1, chr, 1'b0, KIND_ERR, '0);
                    n_v           = n_v + 2'd1;
                    consume_v     = 1'b1;
                end
            end
            default:
            begin
                if (chr == CH_NUL)
                begin
                    res_v[n_v[0]] = mk(1'b0, CH_NUL, 1'b1, KIND_END, '0);
                    n_v           = n_v + 2'd1;
                    phase_next    = PH_START;
                    cnt_next      = '0;
                    len_next      = '0;
                end
                else if (chr == CH_LT || chr == CH_GT || chr == CH_AMP)
                begin
                    res_v[n_v[0]] = mk(1'b1, chr, 1'b1,
                                       (chr == CH_LT) ? KIND_IN :
                                       (chr == CH_GT) ? KIND_OUT : KIND_RUN,
                                       CNT_W'(1));
                    n_v           = n_v + 2'd1;
                    phase_next    = PH_START;
                    cnt_next      = '0;
                    len_next      = '0;
                end
                else if (chr == CH_LPAR)
                begin
                    phase_next = PH_ARG;
                    consume_v  = 1'b1;
                end
                else if (is_space(chr))
                begin
                    consume_v = 1'b1;
                end
                else if (is_name_char(chr))
                begin
                    len_next      = CNT_W'(1);
                    phase_next    = PH_NAME;
                    res_v[n_v[0]] = mk(1'b1, chr, 1'b0, KIND_ERR, '0);
                    n_v           = n_v + 2'd1;
                    consume_v     = 1'b1;
                end
                else
                begin
                    // drop the offending character
                    res_v[n_v[0]] = mk(1'b0, CH_NUL, 1'b1, KIND_ERR, '0);
                    n_v           = n_v + 2'd1;
                    phase_next    = PH_START;
                    cnt_next      = '0;
                    len_next      = '0;
                end
            end
        endcase

        // size limit: fold the error end into the last open character request, or add one
        if (consume_v)
        begin
            cnt_inc = cnt_next + 1'b1;
            if (cnt_inc >= LIMIT)
            begin
                last_idx = 1'(n_v - 2'd1);
                if (n_v != 2'd0 && !res_v[last_idx].token_done)
                begin
                    res_v[last_idx].token_done   = 1'b1;
                    res_v[last_idx].token_kind   = KIND_ERR;
                    res_v[last_idx].token_length = TLEN_W'(len_next);
                end
                else
                begin
                    res_v[n_v[0]] = mk(1'b0, CH_NUL, 1'b1, KIND_ERR, len_next);
                    n_v           = n_v + 2'd1;
                end
                phase_next = PH_START;
                cnt_next   = '0;
                len_next   = '0;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end

        if (n_v != 2'd0)
        begin
            res_v[1'(n_v - 2'd1)].run_last = 1'b1;
        end
    end

    assign res     = res_v;
    assign res_cnt = n_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            cnt_reg   <= '0;
            len_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
        end
    end

    a_cnt_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < LIMIT)
        else $error("consumed count reached the size limit without clearing");

    a_first_of_two_done: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_cnt == 2'd2) |-> (res[0].token_done && !res[0].run_last))
        else $error("first of two requests must close a token");

endmodule

[src/scm_queue.sv]
`timescale 1ns / 1ps

module scm_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [1:0]                       push_cnt,
    input  scm_pkg::result_t [1:0]           push_data,
    input  logic                             pop,
    output scm_pkg::result_t                 head,
    output logic                             not_empty,
    output logic [scm_pkg::QCNT_W-1:0]       count
);
    import scm_pkg::*;

    result_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_data[0];
        end
        if (push_cnt == 2'd2)
        begin
            mem[QPTR_W'(wr_ptr_reg + 1'b1)] <= push_data[1];
        end
    end

    always_comb
    begin
        wr_ptr_next = QPTR_W'(wr_ptr_reg + QPTR_W'(push_cnt));
        rd_ptr_next = QPTR_W'(rd_ptr_reg + QPTR_W'(pop));
        count_next  = QCNT_W'(count_reg + QCNT_W'(push_cnt) - QCNT_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ((QCNT_W + 1)'(count_reg) + (QCNT_W + 1)'(push_cnt)) <=
        (QCNT_W + 1)'(QUEUE_DEPTH) + (QCNT_W + 1)'(pop))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("result queue popped while empty");

endmodule

[src/shell_command_tokenizer.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+-------------------------------------
// chr      | in        | chr_valid / chr_ready | in_char
// tok      | out       | tok_valid / tok_ready | char_valid, out_char, token_done,
//          |           |                       | token_kind, token_length, run_last
//
// One character a cycle is taken while the queue has room; it waits in the input
// register, where the scan logic turns it into zero, one or two requests pushed
// into a four-entry queue. The first request is offered from the queue once the scan
// has written it there.
// The input register only advances while the queue has room for two requests, so a
// stall on tok backs up into chr_ready after the queue fills.
// Reset clears the scan phase, counters and the queue; no clearing pass is needed.
module shell_command_tokenizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          chr_valid,
    output logic                          chr_ready,
    input  logic [scm_pkg::CHAR_W-1:0]    in_char,
    output logic                          tok_valid,
    input  logic                          tok_ready,
    output logic                          char_valid,
    output logic [scm_pkg::CHAR_W-1:0]    out_char,
    output logic                          token_done,
    output logic [scm_pkg::KIND_W-1:0]    token_kind,
    output logic [scm_pkg::TLEN_W-1:0]    token_length,
    output logic                          run_last
);
    import scm_pkg::*;

    logic [CHAR_W-1:0]  char_reg;
    logic               busy_reg;
    logic               fire;
    result_t [1:0]      res;
    logic [1:0]         res_cnt;
    result_t            head;
    logic               not_empty;
    logic [QCNT_W-1:0]  q_count;

    assign fire      = busy_reg && (q_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign chr_ready = !busy_reg || fire;

    always_ff @(posedge clk)
    begin
        if (chr_valid && chr_ready)
        begin
            char_reg <= in_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (chr_valid && chr_ready)
        begin
            busy_reg <= 1'b1;
        end
        else if (fire)
        begin
            busy_reg <= 1'b0;
        end
    end

    scm_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (fire),
        .chr     (char_reg),
        .res     (res),
        .res_cnt (res_cnt)
    );

    scm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (fire ? res_cnt : 2'd0),
        .push_data (res),
        .pop       (tok_valid && tok_ready),
        .head      (head),
        .not_empty (not_empty),
        .count     (q_count)
    );

    assign tok_valid    = not_empty;
    assign char_valid   = head.char_valid;
    assign out_char     = head.out_char;
    assign token_done   = head.token_done;
    assign token_kind   = head.token_kind;
    assign token_length = head.token_length;
    assign run_last     = head.run_last;

endmodule
